/* src/mcg_pkg.sv */
package mcg_pkg;

   localparam int GROUP_W  = 32;
   localparam int COUNT_W  = 16;
   localparam int PORT_W   = 16;
   localparam int STATUS_W = 3;
   localparam int IDXOUT_W = 4;
   localparam int CSR_W    = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_COUNT_UP   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SLOTS_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TRACK_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_COUNT_DOWN = 3'd5;
   localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd6;

   localparam logic ACT_JOIN  = 1'b0;
   localparam logic ACT_LEAVE = 1'b1;

   localparam logic CSR_KERNEL_MODE = 1'b0;
   localparam logic CSR_LISTEN_PORT = 1'b1;

   typedef struct packed {
      logic               action;
      logic [GROUP_W-1:0] group_addr;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                slot_write;
      logic [IDXOUT_W-1:0] slot_index;
      logic [GROUP_W-1:0]  slot_group;
      logic [PORT_W-1:0]   slot_port;
      logic [COUNT_W-1:0]  ref_count;
   } rsp_type;

   typedef struct packed {
      logic pop;
      logic push;
   } mcg_stk_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } mcg_stk_stat_type;

endpackage

/* src/mcg_ram.sv */
module mcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mcg_slot_stack.sv */
module mcg_slot_stack
   import mcg_pkg::*;
#(
   parameter int FILTER_SLOTS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  mcg_stk_ctrl_type                            ctrl,
   input  logic [(FILTER_SLOTS > 1 ? $clog2(FILTER_SLOTS) : 1)-1:0] push_slot,
   output logic [(FILTER_SLOTS > 1 ? $clog2(FILTER_SLOTS) : 1)-1:0] top_slot,
   output mcg_stk_stat_type                            stat
);

   localparam int SLOT_W = FILTER_SLOTS > 1 ? $clog2(FILTER_SLOTS) : 1;
   localparam int CNT_W  = $clog2(FILTER_SLOTS + 1);

   logic [SLOT_W-1:0] stack_ff [FILTER_SLOTS];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  top_ptr;

   assign top_ptr    = count_ff - CNT_W'(1);
   assign top_slot   = stack_ff[top_ptr[SLOT_W-1:0]];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(FILTER_SLOTS));

   always_comb begin
      count_in = count_ff;
      if (ctrl.pop && !stat.empty) begin
         count_in = count_ff - CNT_W'(1);
      end else if (ctrl.push && !stat.full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FILTER_SLOTS; i++) begin
            stack_ff[i] <= SLOT_W'(FILTER_SLOTS - 1 - i);
         end
         count_ff <= CNT_W'(FILTER_SLOTS);
      end else begin
         // drop a push onto a full stack
         if (ctrl.push && !ctrl.pop && !stat.full) begin
            stack_ff[count_ff[SLOT_W-1:0]] <= push_slot;
         end
         count_ff <= count_in;
      end
   end

endmodule

/* src/multicast_group_refcount_table_top.sv */
// A hit on the lookup scan ends the search early; otherwise the scan reads one tracking
// entry per cycle through the single entry RAM read port. A new request is taken only
// when busy is low, after the previous one has finished.
// The receiver cannot stall: rsp_valid is high for a single cycle, and rsp_data holds
// each result until the next one.
// Synchronous active-high reset clears all valid bits, refills the slot stack and
// zeroes both configuration registers; it needs no clearing pass.
module multicast_group_refcount_table_top
   import mcg_pkg::*;
#(
   parameter int FILTER_SLOTS  = 16,
   parameter int TRACK_ENTRIES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int SLOT_W = FILTER_SLOTS > 1 ? $clog2(FILTER_SLOTS) : 1;
   localparam int IDX_W  = TRACK_ENTRIES > 1 ? $clog2(TRACK_ENTRIES) : 1;
   localparam int ENT_W  = GROUP_W + COUNT_W + 1 + SLOT_W;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACK_ENTRIES - 1);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]               state_ff, state_in;
   req_type                  req_ff, req_in;
   logic [IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic                     issue_ff, issue_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   logic [COUNT_W-1:0]       hit_count_ff, hit_count_in;
   logic                     hit_has_slot_ff, hit_has_slot_in;
   logic [SLOT_W-1:0]        hit_slot_ff, hit_slot_in;
   logic                     empty_found_ff, empty_found_in;
   logic [IDX_W-1:0]         empty_idx_ff, empty_idx_in;
   logic [TRACK_ENTRIES-1:0] valid_ff, valid_in;
   logic                     kernel_mode_ff;
   logic [PORT_W-1:0]        listen_port_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // entry RAM
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [ENT_W-1:0] ram_wdata;
   logic             ram_re;
   logic [ENT_W-1:0] ram_rdata;

   logic [GROUP_W-1:0] rd_group;
   logic [COUNT_W-1:0] rd_count;
   logic               rd_has_slot;
   logic [SLOT_W-1:0]  rd_slot;
   logic               match;

   // shared count unit
   logic [COUNT_W-1:0] count_adj;

   // free slot stack
   mcg_stk_ctrl_type   stk_ctrl;
   mcg_stk_stat_type   stk_stat;
   logic [SLOT_W-1:0]  stk_top;

   mcg_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TRACK_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rdata)
   );

   mcg_slot_stack #(
      .FILTER_SLOTS (FILTER_SLOTS)
   ) u_slot_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (stk_ctrl),
      .push_slot (hit_slot_ff),
      .top_slot  (stk_top),
      .stat      (stk_stat)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // entry layout: group, count, has_slot, slot
   assign rd_group    = ram_rdata[ENT_W-1 -: GROUP_W];
   assign rd_count    = ram_rdata[SLOT_W+1 +: COUNT_W];
   assign rd_has_slot = ram_rdata[SLOT_W];
   assign rd_slot     = ram_rdata[SLOT_W-1:0];

   assign ram_re = (state_ff == S_SCAN) && issue_ff;
   assign match  = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_group == req_ff.group_addr);

   // one add serves both increment and decrement
   assign count_adj = hit_count_ff +
                      ((req_ff.action == ACT_LEAVE) ? COUNT_MAX : COUNT_W'(1));

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      scan_idx_in     = scan_idx_ff;
      issue_in        = issue_ff;
      cmp_vld_in      = 1'b0;
      cmp_idx_in      = scan_idx_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_count_in    = hit_count_ff;
      hit_has_slot_in = hit_has_slot_ff;
      hit_slot_in     = hit_slot_ff;
      empty_found_in  = empty_found_ff;
      empty_idx_in    = empty_idx_ff;
      valid_in        = valid_ff;
      rsp_valid_in    = 1'b0;
      rsp_data_in     = rsp_data_ff;
      ram_we          = 1'b0;
      ram_waddr       = hit_idx_ff;
      ram_wdata       = {req_ff.group_addr, count_adj, hit_has_slot_ff, hit_slot_ff};
      stk_ctrl        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in         = req_data;
               scan_idx_in    = '0;
               issue_in       = 1'b1;
               hit_in         = 1'b0;
               empty_found_in = 1'b0;
               state_in       = S_SCAN;
            end
         end

         S_SCAN: begin
            // issue the next read and note the lowest free entry on the way
            if (issue_ff) begin
               cmp_vld_in = 1'b1;
               if (!valid_ff[scan_idx_ff] && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_idx_in   = scan_idx_ff;
               end
               if (scan_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
            // compare the entry read last cycle
            if (match) begin
               hit_in          = 1'b1;
               hit_idx_in      = cmp_idx_ff;
               hit_count_in    = rd_count;
               hit_has_slot_in = rd_has_slot;
               hit_slot_in     = rd_slot;
               issue_in        = 1'b0;
               cmp_vld_in      = 1'b0;
               state_in        = S_DONE;
            end else if (cmp_vld_ff && cmp_idx_ff == LAST_IDX) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            state_in     = S_IDLE;
            if (req_ff.action == ACT_JOIN) begin
               if (hit_ff) begin
                  // saturate at the top of the count range
                  rsp_data_in.status = ST_COUNT_UP;
                  if (hit_count_ff == COUNT_MAX) begin
                     rsp_data_in.ref_count = COUNT_MAX;
                  end else begin
                     rsp_data_in.ref_count = count_adj;
                     ram_we                = 1'b1;
                  end
               end else if (!kernel_mode_ff && stk_stat.empty) begin
                  rsp_data_in.status = ST_SLOTS_FULL;
               end else if (!empty_found_ff) begin
                  rsp_data_in.status = ST_TRACK_FULL;
               end else begin
                  valid_in[empty_idx_ff] = 1'b1;
                  ram_we                 = 1'b1;
                  ram_waddr              = empty_idx_ff;
                  rsp_data_in.status     = ST_ADDED;
                  rsp_data_in.ref_count  = COUNT_W'(1);
                  if (kernel_mode_ff) begin
                     ram_wdata = {req_ff.group_addr, COUNT_W'(1), 1'b0, SLOT_W'(0)};
                  end else begin
                     // pop a slot and report the filter write
                     stk_ctrl.pop           = 1'b1;
                     ram_wdata = {req_ff.group_addr, COUNT_W'(1), 1'b1, stk_top};
                     rsp_data_in.slot_write = 1'b1;
                     rsp_data_in.slot_index = IDXOUT_W'(stk_top);
                     rsp_data_in.slot_group = req_ff.group_addr;
                     rsp_data_in.slot_port  = listen_port_ff;
                  end
               end
            end else begin
               if (!hit_ff) begin
                  rsp_data_in.status = ST_UNKNOWN;
               end else if (hit_count_ff > COUNT_W'(1)) begin
                  ram_we                = 1'b1;
                  rsp_data_in.status    = ST_COUNT_DOWN;
                  rsp_data_in.ref_count = count_adj;
               end else begin
                  // last reference gone: drop the entry and free its slot if it has one
                  valid_in[hit_idx_ff] = 1'b1 ^ 1'b1;
                  rsp_data_in.status   = ST_REMOVED;
                  if (hit_has_slot_ff) begin
                     stk_ctrl.push          = 1'b1;
                     rsp_data_in.slot_write = 1'b1;
                     rsp_data_in.slot_index = IDXOUT_W'(hit_slot_ff);
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         issue_ff       <= 1'b0;
         cmp_vld_ff     <= 1'b0;
         hit_ff         <= 1'b0;
         empty_found_ff <= 1'b0;
         valid_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         kernel_mode_ff <= 1'b0;
         listen_port_ff <= '0;
      end else begin
         state_ff       <= state_in;
         issue_ff       <= issue_in;
         cmp_vld_ff     <= cmp_vld_in;
         hit_ff         <= hit_in;
         empty_found_ff <= empty_found_in;
         valid_ff       <= valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_KERNEL_MODE: kernel_mode_ff <= csr_wdata[0];
               CSR_LISTEN_PORT: listen_port_ff <= csr_wdata[PORT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      scan_idx_ff     <= scan_idx_in;
      cmp_idx_ff      <= cmp_idx_in;
      hit_idx_ff      <= hit_idx_in;
      hit_count_ff    <= hit_count_in;
      hit_has_slot_ff <= hit_has_slot_in;
      hit_slot_ff     <= hit_slot_in;
      empty_idx_ff    <= empty_idx_in;
      rsp_data_ff     <= rsp_data_in;
   end

endmodule
